// ===== design/dscb_pkg.sv =====
// Shared types and constants for the DAC setpoint command builder.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package dscb_pkg;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_KIND      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JUSTIFY_SHIFT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RANGE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_LOW          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH         = 3'd5;

	localparam logic [16:0] RST_FULL_SCALE_COUNT = 17'd4096;
	localparam logic [2:0]  RST_JUSTIFY_SHIFT    = 3'd4;
	localparam logic [15:0] RST_OUTPUT_RANGE     = 16'd10000;

	// Frame and calibration constants
	localparam logic [7:0]  CHANNEL_REG    = 8'd2;
	localparam logic [15:0] CAL_POINT_LOW  = 16'd4000;
	localparam logic [15:0] CAL_POINT_HIGH = 16'd20000;
	localparam logic [15:0] CAL_SPAN       = 16'd16000;

	// Datapath widths: 17x16 product, dividend with rounding offset, quotient bound
	localparam int unsigned PROD_W     = 33;
	localparam int unsigned DVD_W      = 34;
	localparam int unsigned QUO_W      = 18;
	localparam int unsigned DIV_BPS    = 3;
	localparam int unsigned DIV_STAGES = QUO_W / DIV_BPS;

	// Queue between front and back
	localparam int unsigned QDEPTH = 16;
	localparam int unsigned QAW    = 4;

	typedef struct packed {
		logic        output_kind;
		logic [16:0] full_scale_count;
		logic [2:0]  justify_shift;
		logic [15:0] output_range;
		logic [15:0] cal_low;
		logic [15:0] cal_high;
	} cfg_t;

	// Side band that rides along with the divider
	typedef struct packed {
		logic       err;
		logic       interp;
		logic       zero;
		logic       neg;
		logic       both;
		logic [7:0] cmd;
	} tag_t;

	// One classified and computed item, ready for framing
	typedef struct packed {
		logic        err;
		logic        both;
		logic [7:0]  cmd;
		logic [15:0] code;
	} entry_t;

	typedef struct packed {
		logic empty;
		logic room;
	} qstat_t;

endpackage

// ===== design/dscb_div.sv =====
// Pipelined restoring divider, a few quotient bits per stage.
// Depends on dscb_pkg. Quotient must fit QUO_W bits (dividend top < divisor).
`timescale 1ns / 1ps

module dscb_div
	import dscb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [DVD_W-1:0] dividend,
	input  logic [15:0]      divisor,
	input  tag_t             in_tag,
	output logic             out_valid,
	output logic [QUO_W-1:0] quotient,
	output tag_t             out_tag
);

	logic [15:0]      rem_s [DIV_STAGES];
	logic [QUO_W-1:0] wrk_s [DIV_STAGES];
	logic [15:0]      dvs_s [DIV_STAGES];
	tag_t             tag_s [DIV_STAGES];
	logic             vld_s [DIV_STAGES];

	logic [15:0]      rem_nx [DIV_STAGES];
	logic [QUO_W-1:0] wrk_nx [DIV_STAGES];
	logic [15:0]      dvs_in [DIV_STAGES];

	// Each stage shifts its next DIV_BPS dividend bits into the partial remainder
	// and leaves the quotient bits behind in the work word.
	always_comb begin
		logic [15:0]      r;
		logic [QUO_W-1:0] w;
		logic [16:0]      t;
		logic             qb;
		for (int g = 0; g < DIV_STAGES; g++) begin
			if (g == 0) begin
				r = dividend[DVD_W-1:QUO_W];
				w = dividend[QUO_W-1:0];
				dvs_in[g] = divisor;
			end else begin
				r = rem_s[g-1];
				w = wrk_s[g-1];
				dvs_in[g] = dvs_s[g-1];
			end
			for (int k = 0; k < DIV_BPS; k++) begin
				t = {r, w[QUO_W-1]};
				if (t >= {1'b0, dvs_in[g]}) begin
					r  = 16'(t - {1'b0, dvs_in[g]});
					qb = 1'b1;
				end else begin
					r  = t[15:0];
					qb = 1'b0;
				end
				w = {w[QUO_W-2:0], qb};
			end
			rem_nx[g] = r;
			wrk_nx[g] = w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < DIV_STAGES; g++) vld_s[g] <= 1'b0;
		end else begin
			for (int g = 0; g < DIV_STAGES; g++) begin
				vld_s[g] <= (g == 0) ? in_valid : vld_s[g-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < DIV_STAGES; g++) begin
			rem_s[g] <= rem_nx[g];
			wrk_s[g] <= wrk_nx[g];
			dvs_s[g] <= dvs_in[g];
			tag_s[g] <= (g == 0) ? in_tag : tag_s[g-1];
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign quotient  = wrk_s[DIV_STAGES-1];
	assign out_tag   = tag_s[DIV_STAGES-1];

endmodule

// ===== design/dscb_front.sv =====
// Front part: takes setpoints, range-checks and classifies them, multiplies,
// divides and justifies the code. Depends on dscb_pkg and dscb_div.
`timescale 1ns / 1ps

module dscb_front
	import dscb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        take,
	input  logic [15:0] setpoint,
	input  logic [1:0]  channel_select,
	output logic        push,
	output entry_t      push_entry
);

	logic              v_s1;
	logic [15:0]       sp_s1;
	logic [1:0]        ch_s1;

	logic              v_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [15:0]       off_s2;
	logic [15:0]       dvs_s2;
	tag_t              tag_s2;

	logic              v_s3;
	entry_t            ent_s3;

	// stage 1 classification
	logic        err, interp, neg, both;
	logic [16:0] fsm1, diff, mag_full;
	logic [15:0] dsp;
	logic [16:0] mul_a;
	logic [15:0] mul_b;
	logic [7:0]  cmd;
	tag_t        tag_c;

	always_comb begin
		err    = sp_s1 > cfg.output_range;
		interp = cfg.output_kind && (cfg.cal_low != 16'd0) && (cfg.cal_high != 16'd0)
			&& (sp_s1 >= CAL_POINT_LOW) && (sp_s1 <= CAL_POINT_HIGH);
		fsm1     = (cfg.full_scale_count != 17'd0) ? cfg.full_scale_count - 17'd1 : 17'd0;
		diff     = {1'b0, cfg.cal_high} - {1'b0, cfg.cal_low};
		neg      = diff[16];
		mag_full = neg ? 17'd0 - diff : diff;
		dsp      = sp_s1 - CAL_POINT_LOW;
		mul_a    = interp ? {1'b0, mag_full[15:0]} : fsm1;
		mul_b    = interp ? dsp : sp_s1;
		both     = ch_s1[1];
		cmd      = both ? CHANNEL_REG : CHANNEL_REG << ch_s1[0];
		tag_c.err    = err;
		tag_c.interp = interp;
		tag_c.zero   = !interp && (cfg.output_range == 16'd0);
		tag_c.neg    = neg;
		tag_c.both   = both;
		tag_c.cmd    = cmd;
	end

	// divider
	logic [DVD_W-1:0] dividend;
	logic             dv_valid;
	logic [QUO_W-1:0] quo;
	tag_t             dv_tag;

	assign dividend = DVD_W'(prod_s2) + DVD_W'(off_s2);

	dscb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.dividend  (dividend),
		.divisor   (dvs_s2),
		.in_tag    (tag_s2),
		.out_valid (dv_valid),
		.quotient  (quo),
		.out_tag   (dv_tag)
	);

	// finish: apply sign and calibration offset, then justify
	logic [15:0] q16, qsgn, code, code_sh;
	entry_t      ent_c;

	always_comb begin
		q16  = quo[15:0];
		qsgn = dv_tag.neg ? 16'd0 - q16 : q16;
		if (dv_tag.interp) begin
			code = cfg.cal_low + qsgn;
		end else if (dv_tag.zero) begin
			code = 16'd0;
		end else begin
			code = q16;
		end
		code_sh    = code << cfg.justify_shift;
		ent_c.err  = dv_tag.err;
		ent_c.both = dv_tag.both;
		ent_c.cmd  = dv_tag.cmd;
		ent_c.code = code_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sp_s1 <= setpoint;
			ch_s1 <= channel_select;
		end
		prod_s2 <= PROD_W'(mul_a) * PROD_W'(mul_b);
		off_s2  <= interp ? 16'd0 : {1'b0, cfg.output_range[15:1]};
		dvs_s2  <= interp ? CAL_SPAN : cfg.output_range;
		tag_s2  <= tag_c;
		ent_s3  <= ent_c;
	end

	assign push       = v_s3;
	assign push_entry = ent_s3;

endmodule

// ===== design/dscb_queue.sv =====
// Queue of computed items between front and back, with slot reservation
// so the non-stalling front pipeline never overfills it. Depends on dscb_pkg.
`timescale 1ns / 1ps

module dscb_queue
	import dscb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   reserve,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output qstat_t stat
);

	entry_t         mem_q [QDEPTH];
	logic [QAW:0]   wr_q, rd_q;
	logic [QAW:0]   credit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			rd_q     <= '0;
			credit_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			// hold a slot from transfer in until the item leaves the queue
			credit_q <= credit_q + (QAW+1)'(reserve) - (QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q[QAW-1:0]] <= push_entry;
	end

	assign head       = mem_q[rd_q[QAW-1:0]];
	assign stat.empty = (wr_q == rd_q);
	assign stat.room  = (credit_q < (QAW+1)'(QDEPTH));

endmodule

// ===== design/dscb_back.sv =====
// Back part: walks each queued item through its frame bytes and drives the
// registered result channel. Depends on dscb_pkg.
`timescale 1ns / 1ps

module dscb_back
	import dscb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  qstat_t     qstat,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] frame_byte,
	output logic       last,
	output logic       status
);

	typedef enum logic [2:0] {
		SLOT_CMD,
		SLOT_LO0,
		SLOT_HI0,
		SLOT_LO1,
		SLOT_HI1
	} slot_t;

	slot_t      idx_q;
	entry_t     cur_q;
	logic       cur_vld_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       status_q;

	logic       advance, cur_last, load;
	logic [7:0] byte_c;

	always_comb begin
		advance  = cur_vld_q && (!out_valid_q || out_ready);
		cur_last = cur_q.err || (idx_q == SLOT_HI1) || (!cur_q.both && idx_q == SLOT_HI0);
		load     = !qstat.empty && (!cur_vld_q || (advance && cur_last));
		case (idx_q)
			SLOT_CMD: byte_c = cur_q.cmd;
			SLOT_LO0: byte_c = cur_q.code[7:0];
			SLOT_HI0: byte_c = cur_q.code[15:8];
			SLOT_LO1: byte_c = cur_q.code[7:0];
			SLOT_HI1: byte_c = cur_q.code[15:8];
			default:  byte_c = 8'd0;
		endcase
		if (cur_q.err) byte_c = 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= SLOT_CMD;
			cur_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				byte_q      <= byte_c;
				last_q      <= cur_last;
				status_q    <= cur_q.err;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				cur_q     <= head;
				cur_vld_q <= 1'b1;
				idx_q     <= SLOT_CMD;
			end else if (advance) begin
				if (cur_last) cur_vld_q <= 1'b0;
				else          idx_q     <= slot_t'(idx_q + 3'd1);
			end
		end
	end

	assign pop        = load;
	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last       = last_q;
	assign status     = status_q;

endmodule

// ===== design/dac_setpoint_command_builder_core.sv =====
// Top level of the DAC setpoint command builder: configuration registers,
// front/queue/back wiring and checks. Depends on dscb_pkg and all dscb_ modules.
`timescale 1ns / 1ps

// Each setpoint transfer yields a DAC write frame, one byte per result
// transfer: a command byte, then the low and high bytes of the justified
// code (single channel, three bytes), or the command byte followed by the
// code bytes twice (both channels, five bytes). A setpoint above
// output_range yields one result with frame_byte 0, last 1 and status 1.
// The front takes a new setpoint every cycle while the internal queue has a
// free slot; it runs a pipeline (input register, multiply, a six-stage
// divider retiring three quotient bits per stage, justify) that feeds the
// queue. The back sends one byte per cycle while out_ready allows, so
// sustained throughput is set by the frame length: five bytes per item for
// both channels, three for a single channel and one for an out-of-range
// setpoint. The 16-entry queue lets the front keep accepting while the
// result side is stalled. Configuration registers are written through the
// cfg port (always ready) and must only change while no item is in flight;
// writes to indexes past the last register are dropped.

module dac_setpoint_command_builder_core
	import dscb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// setpoint channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           setpoint,
	input  logic [1:0]            channel_select,
	// frame byte channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            frame_byte,
	output logic                  last,
	output logic                  status
);

	cfg_t   cfg_q;
	qstat_t qstat;
	logic   take;
	logic   push;
	entry_t push_entry;
	entry_t head;
	logic   pop;

	// Configuration registers; the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_kind      <= 1'b0;
			cfg_q.full_scale_count <= RST_FULL_SCALE_COUNT;
			cfg_q.justify_shift    <= RST_JUSTIFY_SHIFT;
			cfg_q.output_range     <= RST_OUTPUT_RANGE;
			cfg_q.cal_low          <= 16'd0;
			cfg_q.cal_high         <= 16'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OUTPUT_KIND:      cfg_q.output_kind      <= cfg_data[0];
				REG_FULL_SCALE_COUNT: cfg_q.full_scale_count <= cfg_data;
				REG_JUSTIFY_SHIFT:    cfg_q.justify_shift    <= cfg_data[2:0];
				REG_OUTPUT_RANGE:     cfg_q.output_range     <= cfg_data[15:0];
				REG_CAL_LOW:          cfg_q.cal_low          <= cfg_data[15:0];
				REG_CAL_HIGH:         cfg_q.cal_high         <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Admit a setpoint only when a queue slot is free for it; the front
	// pipeline never stalls, so the slot is reserved at transfer time.
	assign in_ready = qstat.room;
	assign take     = in_valid && in_ready;

	dscb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.take           (take),
		.setpoint       (setpoint),
		.channel_select (channel_select),
		.push           (push),
		.push_entry     (push_entry)
	);

	dscb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.reserve    (take),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (qstat)
	);

	dscb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.frame_byte (frame_byte),
		.last       (last),
		.status     (status)
	);

	// Reservation must keep the queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ((u_queue.wr_q - u_queue.rd_q) != (QAW+1)'(QDEPTH)))
		else $error("queue push without a reserved slot");

	// A frame in progress is never cut by an error result.
	a_frame_whole: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> !(out_valid && status))
		else $error("error result inside an open frame");

	// An error result is a single zero byte marked last.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (last && frame_byte == 8'd0))
		else $error("malformed error result");

	// Nothing is popped from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule

// ===== sim/tb_dac_setpoint_command_builder_core.sv =====
// Self-checking testbench for dac_setpoint_command_builder_core: drives setpoints and
// register writes, predicts every frame byte and checks each result transfer in order.
// Depends on dscb_pkg and the design sources; reads no files.
`timescale 1ns / 1ps

module tb_dac_setpoint_command_builder_core;
	import dscb_pkg::*;

	// Expected frame bytes and a private copy of the register file. Every setpoint
	// transfer appends the bytes it must produce; every result transfer pops one.
	class frame_scoreboard;
		typedef struct {
			logic [7:0] fb;
			logic       lst;
			logic       st;
		} frame_beat_t;

		frame_beat_t due_q[$];
		int          errors;
		bit          kind;
		bit [16:0]   fsc;
		bit [2:0]    shift;
		bit [15:0]   rng;
		bit [15:0]   cal_lo;
		bit [15:0]   cal_hi;

		function new();
			errors = 0;
			kind   = 1'b0;
			fsc    = RST_FULL_SCALE_COUNT;
			shift  = RST_JUSTIFY_SHIFT;
			rng    = RST_OUTPUT_RANGE;
			cal_lo = '0;
			cal_hi = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_OUTPUT_KIND:      kind   = data[0];
				REG_FULL_SCALE_COUNT: fsc    = data[16:0];
				REG_JUSTIFY_SHIFT:    shift  = data[2:0];
				REG_OUTPUT_RANGE:     rng    = data[15:0];
				REG_CAL_LOW:          cal_lo = data[15:0];
				REG_CAL_HIGH:         cal_hi = data[15:0];
				default: ;
			endcase
		endfunction

		function void push_beat(logic [7:0] fb, logic lst, logic st);
			frame_beat_t b;
			b.fb  = fb;
			b.lst = lst;
			b.st  = st;
			due_q.push_back(b);
		endfunction

		// Work out the frame for one accepted setpoint.
		function void note_setpoint(logic [15:0] sp, logic [1:0] ch);
			longint          sp_s, lo_s, hi_s, pt_s, span_s, q;
			longint unsigned sp_u, fsm1, rng_u, quo;
			logic [15:0]     code;
			logic [7:0]      cmd;
			bit              both;
			if (sp > rng) begin
				push_beat(8'd0, 1'b1, 1'b1);
				return;
			end
			if (kind && cal_lo != 0 && cal_hi != 0 &&
			    sp >= CAL_POINT_LOW && sp <= CAL_POINT_HIGH) begin
				// signed two-point interpolation, quotient truncated toward zero
				sp_s   = sp;
				lo_s   = cal_lo;
				hi_s   = cal_hi;
				pt_s   = CAL_POINT_LOW;
				span_s = CAL_SPAN;
				q      = ((sp_s - pt_s) * (hi_s - lo_s)) / span_s;
				q      = lo_s + q;
				code   = q[15:0];
			end else if (rng == 0) begin
				code = '0;
			end else begin
				sp_u  = sp;
				rng_u = rng;
				fsm1  = (fsc >= 1) ? fsc - 1 : 0;
				quo   = (sp_u * fsm1 + rng_u / 2) / rng_u;
				code  = quo[15:0];
			end
			code = code << shift;
			both = (ch >= 2);
			cmd  = both ? CHANNEL_REG : 8'(CHANNEL_REG << ch);
			push_beat(cmd, 1'b0, 1'b0);
			push_beat(code[7:0], 1'b0, 1'b0);
			push_beat(code[15:8], !both, 1'b0);
			if (both) begin
				push_beat(code[7:0], 1'b0, 1'b0);
				push_beat(code[15:8], 1'b1, 1'b0);
			end
		endfunction

		function void check_byte(logic [7:0] fb, logic lst, logic st);
			frame_beat_t b;
			if (due_q.size() == 0) begin
				$error("frame_byte transfer with nothing pending: frame_byte %0h last %0b status %0b",
				       fb, lst, st);
				errors++;
				return;
			end
			b = due_q.pop_front();
			if (fb !== b.fb) begin
				$error("frame_byte: expected %0h, got %0h", b.fb, fb);
				errors++;
			end
			if (lst !== b.lst) begin
				$error("last: expected %0b, got %0b", b.lst, lst);
				errors++;
			end
			if (st !== b.st) begin
				$error("status: expected %0b, got %0b", b.st, st);
				errors++;
			end
		endfunction

		function int n_pending();
			return due_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [15:0]           setpoint;
	logic [1:0]            channel_select;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            frame_byte;
	logic                  last;
	logic                  status;

	frame_scoreboard sb;

	// Idle percentages for the sender and the receiver; hold_left forces a long
	// receiver hold-off, counted down by the receiver process itself.
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;

	dac_setpoint_command_builder_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.setpoint       (setpoint),
		.channel_select (channel_select),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.frame_byte     (frame_byte),
		.last           (last),
		.status         (status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up if the run hangs; the slowest correct run is far shorter.
	initial begin
		#5_000_000;
		$display("tb_dac_setpoint_command_builder_core NOT OK");
		$finish;
	end

	// Receiver: change out_ready at the falling edge only. A pending hold-off wins
	// over the random stall.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Check every result transfer against the oldest expected byte.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_byte(frame_byte, last, status);
	end

	// Offer one setpoint: insert random idle cycles first, then hold valid and the
	// payload until the transfer. Return at a falling edge with valid still high, so
	// the next call can keep it up without a drop in between.
	task automatic send_setpoint(input logic [15:0] sp, input logic [1:0] ch);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		setpoint       <= sp;
		channel_select <= ch;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_setpoint(sp, ch);
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected byte has come out, then let the
	// pipeline settle.
	task automatic drain_frames();
		in_valid <= 1'b0;
		while (sb.n_pending() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_setting(input bit kind, input logic [16:0] fsc, input logic [2:0] sh,
	                            input logic [15:0] rng, input logic [15:0] cl,
	                            input logic [15:0] chh);
		drain_frames();
		cfg_write(REG_OUTPUT_KIND, 17'(kind));
		cfg_write(REG_FULL_SCALE_COUNT, fsc);
		cfg_write(REG_JUSTIFY_SHIFT, 17'(sh));
		cfg_write(REG_OUTPUT_RANGE, 17'(rng));
		cfg_write(REG_CAL_LOW, 17'(cl));
		cfg_write(REG_CAL_HIGH, 17'(chh));
	endtask

	// Pick a register setting: mostly legal values, now and then the odd ones
	// (full scale below two or past 17 bits' legal range, oversized shifts).
	task automatic load_random_setting();
		logic [16:0] fsc;
		logic [2:0]  sh;
		logic [15:0] rng;
		logic [15:0] cl;
		logic [15:0] chh;
		case ($urandom_range(0, 5))
			0: fsc = 17'd2;
			1: fsc = 17'd4096;
			2: fsc = 17'd65536;
			3: fsc = 17'($urandom_range(2, 65536));
			4: fsc = 17'($urandom_range(0, 131071));
			default: fsc = 17'd32768;
		endcase
		sh = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		case ($urandom_range(0, 3))
			0: rng = 16'd65535;
			1: rng = 16'($urandom_range(20000, 65535));
			2: rng = 16'($urandom_range(1, 65535));
			default: rng = 16'd24000;
		endcase
		cl  = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
		chh = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
		load_setting(1'($urandom_range(0, 1)), fsc, sh, rng, cl, chh);
	endtask

	// Random setpoint: full 16-bit values for bit coverage and out-of-range hits,
	// a good share inside the calibration window, the rest within range.
	task automatic send_random_setpoint();
		int r;
		int top;
		logic [15:0] sp;
		r   = $urandom_range(0, 99);
		top = (sb.rng < 20000) ? sb.rng : 20000;
		if (r < 15)
			sp = 16'($urandom_range(0, 65535));
		else if (r < 45 && sb.rng >= 4000)
			sp = 16'($urandom_range(4000, top));
		else
			sp = 16'($urandom_range(0, sb.rng));
		send_setpoint(sp, 2'($urandom_range(0, 3)));
	endtask

	task automatic run_phase(input int s_pct, input int r_pct);
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		repeat (2) begin
			load_random_setting();
			repeat (21) send_random_setpoint();
		end
	endtask

	initial begin
		sb             = new();
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		in_valid       = 1'b0;
		setpoint       = '0;
		channel_select = '0;
		out_ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset setting, range edges and every channel select.
		send_setpoint(16'd0, 2'd0);
		send_setpoint(16'd10000, 2'd1);
		send_setpoint(16'd10001, 2'd2);
		send_setpoint(16'd65535, 2'd0);
		send_setpoint(16'd5000, 2'd3);

		// Current mode with calibration: window edges on both sides.
		load_setting(1'b1, 17'd65536, 3'd0, 16'd24000, 16'd1000, 16'd60000);
		send_setpoint(16'd3999, 2'd0);
		send_setpoint(16'd4000, 2'd1);
		send_setpoint(16'd20000, 2'd2);
		send_setpoint(16'd20001, 2'd3);
		send_setpoint(16'd12345, 2'd2);

		// Calibration high below low: negative slope, truncation toward zero.
		load_setting(1'b1, 17'd4096, 3'd4, 16'd65535, 16'd50000, 16'd100);
		send_setpoint(16'd4001, 2'd0);
		send_setpoint(16'd19999, 2'd2);
		// One calibration word zero: fall back to scaling.
		drain_frames();
		cfg_write(REG_CAL_LOW, 17'd0);
		send_setpoint(16'd8000, 2'd1);

		// Zero range (write with an upper bit set, masked to 16 bits), full scale zero.
		load_setting(1'b0, 17'd0, 3'd1, 16'd0, 16'd0, 16'd0);
		cfg_write(REG_OUTPUT_RANGE, 17'h10000);
		send_setpoint(16'd0, 2'd0);
		send_setpoint(16'd1, 2'd1);
		// Writes past the last register must be dropped.
		drain_frames();
		cfg_write(3'd6, 17'd5);
		cfg_write(3'd7, 17'h1ffff);
		send_setpoint(16'd0, 2'd2);

		// Full scale one, then the largest 17-bit count with the largest shift.
		load_setting(1'b0, 17'd1, 3'd0, 16'd1, 16'd0, 16'd0);
		send_setpoint(16'd1, 2'd0);
		load_setting(1'b0, 17'h1ffff, 3'd7, 16'd1, 16'd65535, 16'd65535);
		send_setpoint(16'd1, 2'd3);
		send_setpoint(16'd0, 2'd1);
		load_setting(1'b0, 17'd65536, 3'd4, 16'd65535, 16'd65535, 16'd65535);
		send_setpoint(16'd65535, 2'd2);
		send_setpoint(16'd32767, 2'd0);

		// Random phases: no idling, sender idle, receiver stalling, both.
		run_phase(0, 0);
		run_phase(79, 0);
		run_phase(0, 79);
		run_phase(35, 35);

		// Back-pressure: hold the receiver off while the sender keeps offering
		// two-channel frames, so the queue fills and in_ready drops.
		load_setting(1'b1, 17'd4096, 3'd4, 16'd24000, 16'd800, 16'd4000);
		send_idle_pct  = 0;
		recv_stall_pct = 20;
		hold_left      = 400;
		repeat (30) send_setpoint(16'($urandom_range(0, 24000)), 2'd2);
		// Pause the sender until every frame is out, then finish with a burst.
		drain_frames();
		repeat (10) send_random_setpoint();

		drain_frames();
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_dac_setpoint_command_builder_core OK");
		else
			$display("tb_dac_setpoint_command_builder_core NOT OK");
		$finish;
	end

endmodule

// ===== dac_setpoint_command_builder_core.f =====
design/dscb_pkg.sv
design/dscb_div.sv
design/dscb_front.sv
design/dscb_queue.sv
design/dscb_back.sv
design/dac_setpoint_command_builder_core.sv
sim/tb_dac_setpoint_command_builder_core.sv
